// ----- rtl/core/ring_queue_with_removal_unit_macros.svh -----
// Assertion helpers for the ring queue block.
`ifndef RING_QUEUE_WITH_REMOVAL_UNIT_MACROS_SVH
`define RING_QUEUE_WITH_REMOVAL_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RQR_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define RQR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/rqr_pkg.sv -----
package rqr_pkg;

   localparam int QUEUE_DEPTH = 256;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int ID_W        = 8;
   localparam int MODE_W      = 2;
   localparam int STAT_W      = 2;
   localparam int OCC_W       = 9;

   typedef enum logic [MODE_W-1:0] {
      MODE_ENQ    = 2'd0,
      MODE_POP    = 2'd1,
      MODE_REMOVE = 2'd2,
      MODE_NONE   = 2'd3
   } mode_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_DONE      = 2'd0,
      STAT_FULL      = 2'd1,
      STAT_EMPTY     = 2'd2,
      STAT_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_POP_WAIT,
      S_SCAN,
      S_SHIFT,
      S_REM_END,
      S_MISS_END
   } state_type;

   typedef enum logic [1:0] {
      RD_HEAD,
      RD_NEXT,
      RD_NEXT2
   } rd_sel_type;

   typedef enum logic {
      WR_TAIL,
      WR_SHIFT
   } wr_sel_type;

   typedef enum logic [1:0] {
      COMMIT_NONE,
      COMMIT_ENQ,
      COMMIT_POP,
      COMMIT_REM
   } commit_type;

   typedef enum logic [1:0] {
      RES_ZERO,
      RES_READ,
      RES_OP
   } res_sel_type;

   typedef struct packed {
      logic        load;
      logic        rd_en;
      rd_sel_type  rd_sel;
      logic        wr_en;
      wr_sel_type  wr_sel;
      logic        walk_init;
      logic        walk_adv;
      commit_type  commit;
      logic        finish;
      status_type  status;
      res_sel_type res_sel;
   } cmd_type;

   typedef struct packed {
      mode_type mode;
      logic     empty;
      logic     full;
      logic     match;
      logic     scan_last;
      logic     shift_last;
   } sts_type;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + PTR_W'(1);
   endfunction

   function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
      if (p == '0) begin
         return PTR_W'(QUEUE_DEPTH - 1);
      end
      return p - PTR_W'(1);
   endfunction

endpackage

// ----- rtl/core/rqr_if.sv -----
interface rqr_req_if;
   import rqr_pkg::*;

   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] mode;
   logic [ID_W-1:0]   entry_id;

   modport source (output valid, output mode, output entry_id, input ready);
   modport sink   (input valid, input mode, input entry_id, output ready);
endinterface

interface rqr_rsp_if;
   import rqr_pkg::*;

   logic              valid;
   logic              ready;
   logic [ID_W-1:0]   result_id;
   logic [STAT_W-1:0] status;
   logic [OCC_W-1:0]  occupancy;

   modport source (output valid, output result_id, output status, output occupancy,
                   input ready);
   modport sink   (input valid, input result_id, input status, input occupancy,
                   output ready);
endinterface

// ----- rtl/core/rqr_ctrl.sv -----
module rqr_ctrl
   import rqr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      cmd         = '0;
      cmd.rd_sel  = RD_HEAD;
      cmd.wr_sel  = WR_TAIL;
      cmd.commit  = COMMIT_NONE;
      cmd.status  = STAT_DONE;
      cmd.res_sel = RES_ZERO;

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (sts.mode)
               MODE_ENQ: begin
                  if (out_free) begin
                     cmd.finish = 1'b1;
                     if (sts.full) begin
                        cmd.status = STAT_FULL;
                     end else begin
                        cmd.wr_en  = 1'b1;
                        cmd.wr_sel = WR_TAIL;
                        cmd.commit = COMMIT_ENQ;
                     end
                     state_in = S_IDLE;
                  end
               end
               MODE_POP, MODE_REMOVE: begin
                  if (sts.empty) begin
                     if (out_free) begin
                        cmd.finish = 1'b1;
                        cmd.status = STAT_EMPTY;
                        state_in   = S_IDLE;
                     end
                  end else begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = RD_HEAD;
                     if (sts.mode == MODE_POP) begin
                        state_in = S_POP_WAIT;
                     end else begin
                        cmd.walk_init = 1'b1;
                        state_in      = S_SCAN;
                     end
                  end
               end
               default: begin
                  if (out_free) begin
                     cmd.finish = 1'b1;
                     state_in   = S_IDLE;
                  end
               end
            endcase
         end
         S_POP_WAIT: begin
            if (out_free) begin
               cmd.finish  = 1'b1;
               cmd.commit  = COMMIT_POP;
               cmd.res_sel = RES_READ;
               state_in    = S_IDLE;
            end
         end
         S_SCAN: begin
            // fetch the following slot every cycle: next candidate or first to shift
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_NEXT;
            if (sts.match) begin
               state_in = sts.scan_last ? S_REM_END : S_SHIFT;
            end else if (sts.scan_last) begin
               state_in = S_MISS_END;
            end else begin
               cmd.walk_adv = 1'b1;
            end
         end
         S_SHIFT: begin
            cmd.wr_en    = 1'b1;
            cmd.wr_sel   = WR_SHIFT;
            cmd.rd_en    = 1'b1;
            cmd.rd_sel   = RD_NEXT2;
            cmd.walk_adv = 1'b1;
            if (sts.shift_last) begin
               state_in = S_REM_END;
            end
         end
         S_REM_END: begin
            if (out_free) begin
               cmd.finish  = 1'b1;
               cmd.commit  = COMMIT_REM;
               cmd.res_sel = RES_OP;
               state_in    = S_IDLE;
            end
         end
         S_MISS_END: begin
            if (out_free) begin
               cmd.finish = 1'b1;
               cmd.status = STAT_NOT_FOUND;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in = cmd.finish ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   end

endmodule

// ----- rtl/core/rqr_datapath.sv -----
module rqr_datapath
   import rqr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic [MODE_W-1:0] req_mode,
   input  logic [ID_W-1:0]   req_entry_id,
   input  cmd_type           cmd,
   output sts_type           sts,
   output logic [ID_W-1:0]   rsp_result_id,
   output logic [STAT_W-1:0] rsp_status,
   output logic [OCC_W-1:0]  rsp_occupancy
);

   logic [ID_W-1:0]  mem [QUEUE_DEPTH];

   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [PTR_W-1:0] walk_ff;
   logic [CNT_W-1:0] idx_ff;
   mode_type         mode_ff;
   logic [ID_W-1:0]  op_id_ff;
   logic [ID_W-1:0]  rd_data_ff;
   logic [ID_W-1:0]  res_id_ff;
   status_type       status_ff;
   logic [OCC_W-1:0] occ_ff;

   logic [PTR_W-1:0] rd_addr;
   logic [PTR_W-1:0] wr_addr;
   logic [ID_W-1:0]  wr_data;
   logic [ID_W-1:0]  res_id_in;
   logic [CNT_W:0]   idx_p1;
   logic [CNT_W:0]   idx_p2;

   // storage: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      case (cmd.rd_sel)
         RD_HEAD:  rd_addr = head_ff;
         RD_NEXT:  rd_addr = ptr_inc(walk_ff);
         RD_NEXT2: rd_addr = ptr_inc(ptr_inc(walk_ff));
         default:  rd_addr = head_ff;
      endcase
      if (cmd.wr_sel == WR_SHIFT) begin
         wr_addr = walk_ff;
         wr_data = rd_data_ff;
      end else begin
         wr_addr = tail_ff;
         wr_data = op_id_ff;
      end
   end

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      case (cmd.commit)
         COMMIT_ENQ: begin
            tail_in  = ptr_inc(tail_ff);
            count_in = count_ff + CNT_W'(1);
         end
         COMMIT_POP: begin
            head_in  = ptr_inc(head_ff);
            count_in = count_ff - CNT_W'(1);
         end
         COMMIT_REM: begin
            tail_in  = ptr_dec(tail_ff);
            count_in = count_ff - CNT_W'(1);
         end
         default: begin
         end
      endcase
      case (cmd.res_sel)
         RES_READ: res_id_in = rd_data_ff;
         RES_OP:   res_id_in = op_id_ff;
         default:  res_id_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff  <= mode_type'(req_mode);
         op_id_ff <= req_entry_id;
      end
      if (cmd.walk_init) begin
         walk_ff <= head_ff;
         idx_ff  <= '0;
      end else if (cmd.walk_adv) begin
         walk_ff <= ptr_inc(walk_ff);
         idx_ff  <= idx_ff + CNT_W'(1);
      end
      if (cmd.finish) begin
         res_id_ff <= res_id_in;
         status_ff <= cmd.status;
         occ_ff    <= OCC_W'(count_in);
      end
   end

   assign idx_p1 = {1'b0, idx_ff} + (CNT_W + 1)'(1);
   assign idx_p2 = {1'b0, idx_ff} + (CNT_W + 1)'(2);

   assign sts.mode       = mode_ff;
   assign sts.empty      = (count_ff == '0);
   assign sts.full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign sts.match      = (rd_data_ff == op_id_ff);
   assign sts.scan_last  = (idx_p1 == {1'b0, count_ff});
   assign sts.shift_last = (idx_p2 >= {1'b0, count_ff});

   assign rsp_result_id = res_id_ff;
   assign rsp_status    = status_ff;
   assign rsp_occupancy = occ_ff;

endmodule

// ----- rtl/core/ring_queue_with_removal_unit.sv -----
// Ring queue of 8-bit entry identifiers for scheduler ready and wait lists.
// req_chan carries one operation per transfer: mode enqueue, pop, remove
// or none (ignored), plus entry_id. rsp_chan returns exactly one transfer
// per request with result_id, status and the occupancy left after the
// operation. A remove compares slots from the head up to the match, or
// the whole fill on a miss, then shifts the later entries forward. The
// compare walk and the shift each take one slot per cycle through the single
// read and write port of the slot memory and together cover the fill once.
// One operation is in flight at a time; the next request is taken in the
// cycle after a result is loaded.
// A finished result sits in the output register; the next request is
// taken while it waits, but that request cannot finish until rsp_chan
// drains, so a stalled receiver holds back the queue.
// Synchronous reset empties the queue (head, tail and fill count to zero)
// and clears the output valid; slot contents are left as they are.
`include "ring_queue_with_removal_unit_macros.svh"

module ring_queue_with_removal_unit
   import rqr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   rqr_req_if.sink     req_chan,
   rqr_rsp_if.source   rsp_chan
);

   cmd_type cmd;
   sts_type sts;

   // sequencer: walks the operation, owns both handshakes
   rqr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // slot memory, pointers and the result payload registers
   rqr_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_mode      (req_chan.mode),
      .req_entry_id  (req_chan.entry_id),
      .cmd           (cmd),
      .sts           (sts),
      .rsp_result_id (rsp_chan.result_id),
      .rsp_status    (rsp_chan.status),
      .rsp_occupancy (rsp_chan.occupancy)
   );

   // never overwrite a result the receiver has not taken
   `RQR_ASSERT_SAME(a_finish_free, clock, reset, cmd.finish,
                    !rsp_chan.valid || rsp_chan.ready, "result overwritten while stalled")

   // hold off new requests while an operation is in flight
   `RQR_ASSERT_NEXT(a_busy_after_take, clock, reset, req_chan.valid && req_chan.ready,
                    !req_chan.ready, "request taken while busy")

   // touch the slot memory only while an operation is underway
   `RQR_ASSERT_SAME(a_no_idle_write, clock, reset, cmd.wr_en, !req_chan.ready,
                    "slot write while idle")

   // drop an enqueue to a full queue with a zero identifier
   `RQR_ASSERT_SAME(a_full_zero_id, clock, reset,
                    rsp_chan.valid && (rsp_chan.status == STAT_FULL),
                    rsp_chan.result_id == '0, "full status with nonzero id")

endmodule
